/* hw/rtl/ole_pkg.sv */
// ----------------------------------------------------------------------------
// ole_pkg
// Shared widths, opcodes, status codes and types of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int OP_W      = 3;
	localparam int POS_W     = 5;
	localparam int VAL_W     = 32;
	localparam int STAT_W    = 3;
	localparam int LEN_W     = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT,
		OP_INS_REAR,
		OP_INS_AT,
		OP_DEL_FRONT,
		OP_DEL_REAR,
		OP_DEL_AT,
		OP_FIND,
		OP_DEL_VAL
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL,
		ST_BADPOS,
		ST_NOTFOUND
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// shift command broadcast along the row of cells
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

/* hw/rtl/ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values held in a row of shift cells.
// Timing: done is high in the cycle after the execute cycle.
// Busy is high in the execute cycle, when the cells shift; start is taken only in idle.
// Reset: arst_n clears the count, done and control; entries are undefined.
// The receiver cannot stall: done is high for one cycle; the outputs then hold.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
	parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ole_pkg::OP_W-1:0]          op,
	input  logic [ole_pkg::POS_W-1:0]         position,
	input  logic signed [ole_pkg::VAL_W-1:0]  item_value,
	output logic                              busy,
	output logic                              done,
	output logic [ole_pkg::STAT_W-1:0]        status,
	output logic [ole_pkg::LEN_W-1:0]         found_position,
	output logic [ole_pkg::LEN_W-1:0]         length
);
	import ole_pkg::*;

	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_nxt;
	logic   accept, exec;

	logic [CW-1:0]           count_q, count_nxt;
	op_t                     op_s1;
	logic [POS_W-1:0]        pos_s1;
	logic signed [VAL_W-1:0] val_s1;

	logic                    done_q;
	status_t                 status_q, status_nxt;
	logic [LEN_W-1:0]        found_q, found_nxt;
	logic [LEN_W-1:0]        length_q;

	cell_cmd_t               cmd;
	logic [IW-1:0]           cmd_idx;
	logic [DEPTH-1:0]        valid_vec;
	logic [DEPTH-1:0]        match_vec;
	logic [DEPTH-1:0]        hit_oh;
	logic [IW-1:0]           hit_idx;
	logic                    hit_any;
	logic signed [VAL_W-1:0] cell_data [DEPTH];

	logic [CMPW-1:0] pos_w, pos_m1, cnt_w, ins_at, del_at, hit_w;
	logic            empty, full;

	// control
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy   = 1'b0;
		exec   = 1'b0;
		accept = 1'b0;
		case (state_q)
			S_IDLE: begin
				accept = start;
			end
			S_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			done_q  <= exec;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(op);
			pos_s1 <= position;
			val_s1 <= item_value;
		end
		if (exec) begin
			status_q <= status_nxt;
			found_q  <= found_nxt;
			length_q <= LEN_W'(count_nxt);
		end
	end

	// cell row
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid_vec[i] = CW'(i) < count_q;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VAL_W-1:0] left_d, right_d;
		if (g == 0) begin : g_first
			assign left_d = val_s1;
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_d = cell_data[g];
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end
		ole_cell #(
			.DEPTH    (DEPTH),
			.CELL_IDX (g)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (cmd_idx),
			.cmp_en     (accept),
			.valid      (valid_vec[g]),
			.cmp_value  (item_value),
			.ins_value  (val_s1),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[g]),
			.match      (match_vec[g])
		);
	end

	// first match
	assign hit_oh  = match_vec & (~match_vec + DEPTH'(1));
	assign hit_any = |match_vec;

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_idx = hit_idx | (IW'(i) & {IW{hit_oh[i]}});
		end
	end

	// execute
	assign pos_w  = CMPW'(pos_s1);
	assign pos_m1 = pos_w - CMPW'(1);
	assign cnt_w  = CMPW'(count_q);
	assign hit_w  = CMPW'(hit_idx);
	assign empty  = (count_q == '0);
	assign full   = (count_q == CW'(DEPTH));
	assign ins_at = (pos_w <= CMPW'(1)) ? '0 : ((pos_m1 > cnt_w) ? cnt_w : pos_m1);
	assign del_at = (pos_m1 >= cnt_w) ? (cnt_w - CMPW'(1)) : pos_m1;

	always_comb begin
		cmd        = '0;
		cmd_idx    = '0;
		status_nxt = ST_OK;
		found_nxt  = '0;
		count_nxt  = count_q;
		if (exec) begin
			case (op_s1)
				OP_INS_FRONT, OP_INS_REAR, OP_INS_AT: begin
					if (full) begin
						status_nxt = ST_FULL;
					end else begin
						cmd.ins   = 1'b1;
						count_nxt = count_q + CW'(1);
						if (op_s1 == OP_INS_FRONT) begin
							cmd_idx = '0;
						end else if (op_s1 == OP_INS_REAR) begin
							cmd_idx = IW'(count_q);
						end else begin
							cmd_idx = IW'(ins_at);
						end
					end
				end
				OP_DEL_FRONT, OP_DEL_REAR: begin
					if (empty) begin
						status_nxt = ST_EMPTY;
					end else begin
						cmd.del   = 1'b1;
						count_nxt = count_q - CW'(1);
						cmd_idx   = (op_s1 == OP_DEL_FRONT) ? '0 : IW'(cnt_w - CMPW'(1));
					end
				end
				OP_DEL_AT: begin
					if (empty) begin
						status_nxt = ST_EMPTY;
					end else if (pos_s1 == '0) begin
						status_nxt = ST_BADPOS;
					end else begin
						cmd.del   = 1'b1;
						count_nxt = count_q - CW'(1);
						cmd_idx   = IW'(del_at);
					end
				end
				OP_FIND: begin
					if (empty) begin
						status_nxt = ST_EMPTY;
					end else if (hit_any) begin
						found_nxt = LEN_W'(hit_w + CMPW'(1));
					end else begin
						status_nxt = ST_NOTFOUND;
					end
				end
				OP_DEL_VAL: begin
					if (empty) begin
						status_nxt = ST_EMPTY;
					end else if (hit_any) begin
						cmd.del   = 1'b1;
						count_nxt = count_q - CW'(1);
						cmd_idx   = hit_idx;
					end else begin
						status_nxt = ST_NOTFOUND;
					end
				end
				default: begin
					status_nxt = ST_OK;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign length         = length_q;

endmodule

/* hw/rtl/ole_cell.sv */
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds an entry, compares it against the search value and
// shifts towards or from its neighbours on insert and delete.
// ----------------------------------------------------------------------------
module ole_cell #(
	parameter int DEPTH    = ole_pkg::DEPTH_DEF,
	parameter int CELL_IDX = 0,
	localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  ole_pkg::cell_cmd_t             cmd,
	input  logic [IW-1:0]                  idx,
	input  logic                           cmp_en,
	input  logic                           valid,
	input  logic signed [ole_pkg::VAL_W-1:0] cmp_value,
	input  logic signed [ole_pkg::VAL_W-1:0] ins_value,
	input  logic signed [ole_pkg::VAL_W-1:0] left_data,
	input  logic signed [ole_pkg::VAL_W-1:0] right_data,
	output logic signed [ole_pkg::VAL_W-1:0] data,
	output logic                           match
);
	import ole_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

	logic signed [VAL_W-1:0] data_q;
	logic                    match_s1;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX > idx) begin
				data_q <= left_data;
			end else if (MY_IDX == idx) begin
				data_q <= ins_value;
			end
		end else if (cmd.del && (MY_IDX >= idx)) begin
			data_q <= right_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_s1 <= valid && (data_q == cmp_value);
		end
	end

	assign data  = data_q;
	assign match = match_s1;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ordered_list_engine. Commands are driven through
// the start/busy handshake. A scoreboard keeps its own copy of the list,
// works out the status, found position and length owed for each accepted
// item, and compares every done strobe against the oldest owed result.
// Directed corner cases come first, then biased random traffic that fills
// and drains the list under three sender idling regimes.
// ----------------------------------------------------------------------------
module tb_top;
	import ole_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		status_t           st;
		logic [LEN_W-1:0]  found;
		logic [LEN_W-1:0]  len;
	} list_outcome_t;

	class list_scoreboard;
		logic [VAL_W-1:0] entries [DEPTH_DEF];
		int               fill;
		int               errors;
		list_outcome_t    owed_outcomes [$];

		task report(string msg);
			$display("ERROR %s", msg);
			errors++;
		endtask

		function status_t insert_at(int idx, logic [VAL_W-1:0] v);
			if (fill >= DEPTH_DEF)
				return ST_FULL;
			if (idx > fill)
				idx = fill;
			for (int i = fill; i > idx; i--)
				entries[i] = entries[i-1];
			entries[idx] = v;
			fill++;
			return ST_OK;
		endfunction

		function status_t remove_at(int idx);
			if (fill == 0)
				return ST_EMPTY;
			if (idx >= fill)
				idx = fill - 1;
			for (int i = idx; i + 1 < fill; i++)
				entries[i] = entries[i+1];
			fill--;
			return ST_OK;
		endfunction

		function int locate(logic [VAL_W-1:0] v);
			for (int i = 0; i < fill; i++)
				if (entries[i] == v)
					return i + 1;
			return 0;
		endfunction

		function void note_command(op_t o, logic [POS_W-1:0] pos, logic [VAL_W-1:0] v);
			list_outcome_t res;
			int            hit;
			res.found = '0;
			case (o)
				OP_INS_FRONT: res.st = insert_at(0, v);
				OP_INS_REAR:  res.st = insert_at(fill, v);
				OP_INS_AT:    res.st = insert_at((pos <= 1) ? 0 : int'(pos) - 1, v);
				OP_DEL_FRONT: res.st = remove_at(0);
				OP_DEL_REAR:  res.st = (fill == 0) ? ST_EMPTY : remove_at(fill - 1);
				OP_DEL_AT: begin
					if (fill == 0)
						res.st = ST_EMPTY;
					else if (pos < 1)
						res.st = ST_BADPOS;
					else
						res.st = remove_at(int'(pos) - 1);
				end
				OP_FIND: begin
					if (fill == 0) begin
						res.st = ST_EMPTY;
					end else begin
						hit = locate(v);
						res.found = LEN_W'(hit);
						res.st = (hit != 0) ? ST_OK : ST_NOTFOUND;
					end
				end
				default: begin
					if (fill == 0) begin
						res.st = ST_EMPTY;
					end else begin
						hit = locate(v);
						res.st = (hit != 0) ? remove_at(hit - 1) : ST_NOTFOUND;
					end
				end
			endcase
			res.len = LEN_W'(fill);
			owed_outcomes.push_back(res);
		endfunction

		task check_outcome(logic [STAT_W-1:0] st, logic [LEN_W-1:0] fp,
				logic [LEN_W-1:0] len);
			list_outcome_t want;
			if (owed_outcomes.size() == 0) begin
				report($sformatf("unexpected result: status %0d found %0d length %0d",
					st, fp, len));
			end else begin
				want = owed_outcomes.pop_front();
				if (st !== want.st)
					report($sformatf("status got %0d want %0d", st, want.st));
				if (fp !== want.found)
					report($sformatf("found_position got %0d want %0d", fp, want.found));
				if (len !== want.len)
					report($sformatf("length got %0d want %0d", len, want.len));
			end
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic [OP_W-1:0]          op;
	logic [POS_W-1:0]         position;
	logic signed [VAL_W-1:0]  item_value;
	logic                     busy;
	logic                     done;
	logic [STAT_W-1:0]        status;
	logic [LEN_W-1:0]         found_position;
	logic [LEN_W-1:0]         length;

	list_scoreboard   sb = new;
	int               idle_pct;
	int               quiet_cycles;
	logic [VAL_W-1:0] value_pool [8];

	ordered_list_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.op             (op),
		.position       (position),
		.item_value     (item_value),
		.busy           (busy),
		.done           (done),
		.status         (status),
		.found_position (found_position),
		.length         (length)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_outcome(status, found_position, length);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(op_t o, logic [POS_W-1:0] p, logic [VAL_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		op         <= o;
		position   <= p;
		item_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(o, p, v);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 65)
			return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 99) < 75)
			return POS_W'($urandom_range(0, 17));
		return POS_W'($urandom_range(0, 31));
	endfunction

	// tide_len > 0 alternates insert-heavy and delete-heavy stretches
	task automatic run_random(int n, int tide_len);
		bit  grow;
		int  ins_pct;
		op_t o;
		grow = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (tide_len > 0 && i % tide_len == 0)
				grow = !grow;
			ins_pct = (tide_len > 0) ? (grow ? 80 : 20) : 45;
			if ($urandom_range(0, 99) < ins_pct)
				o = op_t'($urandom_range(0, 2));
			else
				o = op_t'($urandom_range(3, 7));
			if ($urandom_range(0, 99) < 3)
				value_pool[$urandom_range(4, 7)] = $urandom();
			send_item(o, pick_position(), pick_value());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_INS_FRONT;
		position     = '0;
		item_value   = '0;
		quiet_cycles = 0;
		idle_pct     = 11;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// deletes and find on an empty list
		send_item(OP_DEL_FRONT, 5'd0, 32'd0);
		send_item(OP_DEL_REAR, 5'd0, 32'd0);
		send_item(OP_DEL_AT, 5'd0, 32'd0);
		send_item(OP_DEL_AT, 5'd31, 32'd0);
		send_item(OP_FIND, 5'd0, 32'h7fff_ffff);
		send_item(OP_DEL_VAL, 5'd0, 32'h8000_0000);
		// insert position low, past end, plus front and rear
		send_item(OP_INS_AT, 5'd0, 32'h8000_0000);
		send_item(OP_INS_AT, 5'd1, 32'h7fff_ffff);
		send_item(OP_INS_FRONT, 5'd0, 32'hffff_ffff);
		send_item(OP_INS_REAR, 5'd0, 32'h0000_0000);
		send_item(OP_INS_AT, 5'd31, 32'd5);
		send_item(OP_INS_AT, 5'd3, 32'hffff_ffff);
		// delete position zero, find hit and miss, delete by value
		send_item(OP_DEL_AT, 5'd0, 32'd0);
		send_item(OP_FIND, 5'd31, 32'h7fff_ffff);
		send_item(OP_FIND, 5'd0, 32'hffff_ffff);
		send_item(OP_FIND, 5'd0, 32'd12345);
		send_item(OP_DEL_VAL, 5'd0, 32'd12345);
		send_item(OP_DEL_VAL, 5'd0, 32'd5);
		// delete past end and in the middle
		send_item(OP_DEL_AT, 5'd31, 32'd0);
		send_item(OP_DEL_AT, 5'd2, 32'd0);
		send_item(OP_DEL_REAR, 5'd0, 32'd0);
		send_item(OP_DEL_FRONT, 5'd0, 32'd0);
		send_item(OP_DEL_FRONT, 5'd0, 32'd0);

		run_random(220, 40);
		idle_pct = 88;
		run_random(220, 40);
		idle_pct = 0;
		run_random(160, 40);
		run_random(80, 0);

		@(negedge clk);
		start <= 1'b0;
		while (sb.owed_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
